### src/altpid_pkg.sv
package altpid_pkg;

  // Field widths
  localparam int ANG_W  = 19;
  localparam int HGT_W  = 32;
  localparam int DT_W   = 17;
  localparam int YAWR_W = 20;
  localparam int THR_W  = 17;
  localparam int IDX_W  = 2;
  localparam int CFG_W  = 32;

  // Datapath widths
  localparam int ACC_W  = 36;
  localparam int COEF_W = 18;
  localparam int PROD_W = HGT_W + COEF_W;
  localparam int MAG_W  = HGT_W + 1;

  // Q16.16 constants; KYA_INT is a plain integer gain
  localparam logic signed [COEF_W-1:0] KPZ = 18'sd1966;
  localparam logic signed [COEF_W-1:0] KIZ = 18'sd52;
  localparam logic signed [COEF_W-1:0] KDZ = 18'sd2621;
  localparam logic signed [ACC_W-1:0]  HOVER = 36'sd38666;
  localparam logic signed [22:0]       KYA_INT = 23'sd6;
  localparam logic signed [22:0]       MAXYAW = 23'sd288358;
  localparam logic signed [ACC_W-1:0]  ONE_Q16 = 36'sd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_ROLL,
    REG_PITCH,
    REG_YAW,
    REG_HEIGHT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INTEG_MUL,
    ST_INTEG_ADD,
    ST_DIV,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_SUM,
    ST_WIND
  } state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [DT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Floor of a Q16.16 product back to Q16.16
  function automatic logic signed [ACC_W-1:0] sh16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> 16;
    return ACC_W'(s);
  endfunction

endpackage

### src/altpid_if.sv
interface altpid_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [altpid_pkg::IDX_W-1:0]     index;
  logic [altpid_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface altpid_upd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [altpid_pkg::ANG_W-1:0]  yaw_measured;
  logic signed [altpid_pkg::HGT_W-1:0]  height_measured;
  logic [altpid_pkg::DT_W-1:0]          time_step;

  modport source (output valid, action, yaw_measured, height_measured, time_step,
                  input ready);
  modport sink   (input valid, action, yaw_measured, height_measured, time_step,
                  output ready);
endinterface

interface altpid_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [altpid_pkg::ANG_W-1:0]  roll_cmd;
  logic signed [altpid_pkg::ANG_W-1:0]  pitch_cmd;
  logic signed [altpid_pkg::YAWR_W-1:0] yaw_rate_cmd;
  logic [altpid_pkg::THR_W-1:0]         throttle_cmd;

  modport source (output valid, roll_cmd, pitch_cmd, yaw_rate_cmd, throttle_cmd,
                  input ready);
  modport sink   (input valid, roll_cmd, pitch_cmd, yaw_rate_cmd, throttle_cmd,
                  output ready);
endinterface

### src/altpid_div.sv
module altpid_div (
  input  logic                 clk,
  input  logic                 rst,
  input  altpid_pkg::div_req_t req,
  output altpid_pkg::div_rsp_t rsp
);
  import altpid_pkg::*;

  // Quotient bits left once the top of the numerator is known below the divisor
  localparam int ITER  = 31;
  localparam int CNT_W = $clog2(ITER);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DT_W-1:0]    rem;
  logic [DT_W-1:0]    dvs;
  logic [ITER-1:0]    quo;
  logic               neg;
  logic               done;
  logic signed [31:0] quot;

  logic [DT_W:0]      hi;
  logic               ovf;
  logic [DT_W:0]      trial;
  logic               fits;
  logic [ITER-1:0]    quo_next;

  // Numerator is mag shifted up by 16; bits 48:31 of it are mag[32:15]
  assign hi  = req.mag[MAG_W-1:15];
  assign ovf = hi >= {1'b0, req.divisor};

  always_comb begin
    trial    = {rem, quo[ITER-1]};
    fits     = trial >= {1'b0, dvs};
    quo_next = {quo[ITER-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.divisor == '0) begin
          done <= 1'b1;
          quot <= '0;
        end else if (ovf) begin
          done <= 1'b1;
          quot <= req.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(ITER - 1);
          rem  <= hi[DT_W-1:0];
          quo  <= {req.mag[14:0], 16'b0};
          dvs  <= req.divisor;
          neg  <= req.neg;
        end
      end else if (busy) begin
        rem <= fits ? DT_W'(trial - {1'b0, dvs}) : trial[DT_W-1:0];
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

### src/altitude_pid_yaw_p_controller.sv
// An accepted update word steps through the error, integral, divide, P, I,
// D, sum and wind-up states; the divide runs in full (31 quotient steps of
// the shift-subtract divider) unless the time step is zero or the quotient
// saturates. Throughput: one update at a time; the next word is accepted in
// the cycle after the command word is loaded. A clear word gives no word.
// Reset: setpoints, height integral and previous error clear to zero.
module altitude_pid_yaw_p_controller (
  input  logic         clk,
  input  logic         rst,
  altpid_cfg_if.sink   cfg,
  altpid_upd_if.sink   upd,
  altpid_cmd_if.source cmd
);
  import altpid_pkg::*;

  // Setpoint registers
  logic signed [ANG_W-1:0] roll_sp;
  logic signed [ANG_W-1:0] pitch_sp;
  logic signed [ANG_W-1:0] yaw_sp;
  logic signed [HGT_W-1:0] height_sp;

  // Captured update word
  logic signed [ANG_W-1:0] yaw_m;
  logic signed [HGT_W-1:0] height_m;
  logic [DT_W-1:0]         dt;

  // Controller state and working registers
  state_t                   state;
  state_t                   state_next;
  logic signed [31:0]       integ;
  logic signed [31:0]       prev_err;
  logic signed [31:0]       err;
  logic signed [31:0]       deriv;
  logic signed [YAWR_W-1:0] yaw_rate;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;

  // Output word registers
  logic                     out_valid;
  logic signed [ANG_W-1:0]  roll_out;
  logic signed [ANG_W-1:0]  pitch_out;
  logic signed [YAWR_W-1:0] yaw_out;
  logic [THR_W-1:0]         thr_out;

  // Shared multiplier operands
  logic signed [31:0]       mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     upd_fire;
  logic                     out_free;
  logic signed [ACC_W-1:0]  err_diff;
  logic signed [YAWR_W-1:0] yaw_diff;
  logic signed [22:0]       yaw_x6;
  logic signed [YAWR_W-1:0] yaw_clamped;
  logic signed [31:0]       u;
  logic [THR_W-1:0]         thr;
  logic signed [ACC_W-1:0]  wind;
  logic signed [YAWR_W-1:0] roll_neg;

  assign cfg.ready = 1'b1;
  assign upd.ready = (state == ST_IDLE);
  assign upd_fire  = upd.valid && upd.ready;
  // The output register frees up in the same cycle the sink takes it
  assign out_free  = !out_valid || cmd.ready;

  // Setpoint writes
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_sp   <= '0;
      pitch_sp  <= '0;
      yaw_sp    <= '0;
      height_sp <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_ROLL:   roll_sp   <= cfg.data[ANG_W-1:0];
        REG_PITCH:  pitch_sp  <= cfg.data[ANG_W-1:0];
        REG_YAW:    yaw_sp    <= cfg.data[ANG_W-1:0];
        REG_HEIGHT: height_sp <= cfg.data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state, multiplier operand select, divider start
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    case (state)
      ST_IDLE: begin
        if (upd_fire && !upd.action) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        state_next = ST_INTEG_MUL;
      end
      ST_INTEG_MUL: begin
        mul_a      = err;
        mul_b      = $signed({1'b0, dt});
        state_next = ST_INTEG_ADD;
      end
      ST_INTEG_ADD: begin
        div_req.start   = 1'b1;
        div_req.neg     = err_diff[ACC_W-1];
        div_req.mag     = err_diff[ACC_W-1] ? MAG_W'(-err_diff) : MAG_W'(err_diff);
        div_req.divisor = dt;
        state_next      = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_P_MUL;
        end
      end
      ST_P_MUL: begin
        mul_a      = err;
        mul_b      = KPZ;
        state_next = ST_I_MUL;
      end
      ST_I_MUL: begin
        mul_a      = integ;
        mul_b      = KIZ;
        state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        mul_a      = deriv;
        mul_b      = KDZ;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_WIND;
      end
      ST_WIND: begin
        // Hold until the previous command word has left
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Error difference for the derivative divide
  assign err_diff = ACC_W'(err) - ACC_W'(prev_err);

  // Yaw P loop: six times the heading error, clamped to +/-4.4
  always_comb begin
    yaw_diff = YAWR_W'(yaw_sp) - YAWR_W'(yaw_m);
    yaw_x6   = 23'(yaw_diff) * KYA_INT;
    if (yaw_x6 > MAXYAW) begin
      yaw_clamped = YAWR_W'(MAXYAW);
    end else if (yaw_x6 < -MAXYAW) begin
      yaw_clamped = YAWR_W'(-MAXYAW);
    end else begin
      yaw_clamped = yaw_x6[YAWR_W-1:0];
    end
  end

  // Throttle clamp and back-calculation of the integral
  always_comb begin
    u = sat32(acc);
    if (u < 0) begin
      thr = '0;
    end else if (ACC_W'(u) > ONE_Q16) begin
      thr = THR_W'(ONE_Q16);
    end else begin
      thr = u[THR_W-1:0];
    end
    wind = ACC_W'(integ) - ((ACC_W'(u) - ACC_W'($signed({1'b0, thr}))) <<< 1);
  end

  // Roll passes negated; the most negative setpoint saturates
  always_comb begin
    roll_neg = -YAWR_W'(roll_sp);
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      integ     <= '0;
      prev_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (upd_fire) begin
            if (upd.action) begin
              integ    <= '0;
              prev_err <= '0;
            end else begin
              yaw_m    <= upd.yaw_measured;
              height_m <= upd.height_measured;
              dt       <= upd.time_step;
            end
          end
        end
        ST_ERR: begin
          err      <= sat32(ACC_W'(height_sp) - ACC_W'(height_m));
          yaw_rate <= yaw_clamped;
        end
        ST_INTEG_ADD: begin
          integ <= sat32(ACC_W'(integ) + sh16(prod));
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            deriv <= div_rsp.quot;
          end
        end
        ST_P_MUL: begin
          acc <= HOVER;
        end
        ST_I_MUL, ST_D_MUL, ST_SUM: begin
          acc <= acc + sh16(prod);
        end
        ST_WIND: begin
          if (out_free) begin
            integ     <= sat32(wind);
            prev_err  <= err;
            out_valid <= 1'b1;
            roll_out  <= (roll_neg > YAWR_W'(19'sh3FFFF)) ? 19'sh3FFFF
                                                          : roll_neg[ANG_W-1:0];
            pitch_out <= pitch_sp;
            yaw_out   <= yaw_rate;
            thr_out   <= thr;
          end
        end
        default: ;
      endcase
    end
  end

  altpid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cmd.valid        = out_valid;
  assign cmd.roll_cmd     = roll_out;
  assign cmd.pitch_cmd    = pitch_out;
  assign cmd.yaw_rate_cmd = yaw_out;
  assign cmd.throttle_cmd = thr_out;

endmodule
